FILE: hdl/linear_scan_register_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Linear scan register allocator assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_UNIT_ASSERT_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define LSRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define LSRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LSRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/lsra_pkg.sv
// ----------------------------------------------------------------------------
// Linear scan register allocator package
// Fixed port widths, constants and memory control bundles.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // fixed port widths
    localparam int OUT_REG_W = 5;
    localparam int CFG_W     = 6;

    // register count after reset
    localparam int RESET_REGS = 16;

    // register code reported when nothing could be given
    localparam logic [OUT_REG_W-1:0] REG_NONE = '0;

    // active interval memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } am_ctl_t;

    // free list memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } fl_ctl_t;

endpackage

FILE: hdl/lsra_active_mem.sv
// ----------------------------------------------------------------------------
// Active interval memory
// Sorted interval store (end, tag, register), one write and one registered read.
// ----------------------------------------------------------------------------
module lsra_active_mem #(
    parameter int MAX_REGS = 32,
    parameter int ORD_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                          clk,
    input  lsra_pkg::am_ctl_t             ctl,
    input  logic [$clog2(MAX_REGS)-1:0]   rd_addr,
    input  logic [$clog2(MAX_REGS)-1:0]   wr_addr,
    input  logic [ORD_BITS-1:0]           wr_end,
    input  logic [TAG_BITS-1:0]           wr_tag,
    input  logic [$clog2(MAX_REGS)-1:0]   wr_reg,
    output logic [ORD_BITS-1:0]           rd_end,
    output logic [TAG_BITS-1:0]           rd_tag,
    output logic [$clog2(MAX_REGS)-1:0]   rd_reg
);
    import lsra_pkg::*;

    localparam int REG_BITS = $clog2(MAX_REGS);
    localparam int WORD_W   = ORD_BITS + TAG_BITS + REG_BITS;

    logic [WORD_W-1:0] mem [MAX_REGS];
    logic [WORD_W-1:0] rd_word_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= {wr_end, wr_tag, wr_reg};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_end = rd_word_reg[WORD_W-1 -: ORD_BITS];
    assign rd_tag = rd_word_reg[REG_BITS +: TAG_BITS];
    assign rd_reg = rd_word_reg[REG_BITS-1:0];

endmodule

FILE: hdl/lsra_free_list.sv
// ----------------------------------------------------------------------------
// Free register list
// Register stack memory; entries not written since clear read as their index.
// ----------------------------------------------------------------------------
module lsra_free_list #(
    parameter int MAX_REGS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsra_pkg::fl_ctl_t             ctl,
    input  logic [$clog2(MAX_REGS)-1:0]   rd_addr,
    input  logic [$clog2(MAX_REGS)-1:0]   wr_addr,
    input  logic [$clog2(MAX_REGS)-1:0]   wr_data,
    output logic [$clog2(MAX_REGS)-1:0]   rd_data
);
    import lsra_pkg::*;

    localparam int REG_BITS = $clog2(MAX_REGS);

    logic [REG_BITS-1:0] mem [MAX_REGS];
    logic [MAX_REGS-1:0] written_reg;
    logic [MAX_REGS-1:0] written_next;
    logic [REG_BITS-1:0] rd_mem_reg;
    logic [REG_BITS-1:0] rd_idx_reg;
    logic                rd_hit_reg;

    // written flags: clear on reconfiguration, set on push
    always_comb
    begin
        written_next = written_reg;
        if (ctl.clear)
        begin
            written_next = '0;
        end
        else if (ctl.wr_en)
        begin
            written_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read with default-index override
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
            rd_idx_reg <= rd_addr;
            rd_hit_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_mem_reg : rd_idx_reg;

endmodule

FILE: hdl/linear_scan_register_allocator_unit.sv
// ----------------------------------------------------------------------------
// Linear scan register allocator unit
// One live interval in, one register assignment out, state kept in memories.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, active_registers) sets the register
//   count, saturated to MAX_REGS; it empties the active list and refills the
//   free list. It is taken only while the sequencer is idle.
//   in channel carries one interval per transaction in program order; out
//   channel returns one assignment per transaction.
//   From acceptance to out_valid the sequencer handles E expired intervals,
//   S intervals scanned for argument reuse, M entries moved to close the
//   reused slot and I entries moved by the sorted insertion. Every step is
//   one access to the active interval memory, whose single registered read
//   port sets the pace.
//   One item is worked on at a time; the next one is accepted in the idle
//   cycle that follows, once the previous result sits in the output register.
//   Reset: no active intervals, 16 registers free (at most MAX_REGS), no
//   clearing pass is needed.
//   A stalled receiver holds the result; the next item may still be processed
//   and then waits until the output register frees up.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit #(
    parameter int MAX_REGS = 32,
    parameter int ORD_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsra_pkg::CFG_W-1:0]     active_registers,
    // interval input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ORD_BITS-1:0]            def_ordinal,
    input  logic [ORD_BITS-1:0]            end_ordinal,
    input  logic [TAG_BITS-1:0]            value_tag,
    input  logic                           arg_reg_valid,
    input  logic [lsra_pkg::OUT_REG_W-1:0] arg_reg,
    // assignment output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lsra_pkg::OUT_REG_W-1:0] assigned_reg,
    output logic                           reused_arg,
    output logic                           spill_valid,
    output logic [TAG_BITS-1:0]            spilled_tag,
    output logic                           alloc_error
);
    import lsra_pkg::*;

`include "linear_scan_register_allocator_unit_assert.svh"

    localparam int REG_BITS = $clog2(MAX_REGS);
    localparam int CNT_BITS = $clog2(MAX_REGS + 1);
    localparam int INIT_REGS = (RESET_REGS > MAX_REGS) ? MAX_REGS : RESET_REGS;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_EXP_RD   = 14'b00000000000010,
        S_EXP_CHK  = 14'b00000000000100,
        S_SCAN_RD  = 14'b00000000001000,
        S_SCAN_CHK = 14'b00000000010000,
        S_MV_RD    = 14'b00000000100000,
        S_MV_WR    = 14'b00000001000000,
        S_ALLOC    = 14'b00000010000000,
        S_SPILL    = 14'b00000100000000,
        S_FL_HEAD  = 14'b00001000000000,
        S_FL_MOVE  = 14'b00010000000000,
        S_INS_RD   = 14'b00100000000000,
        S_INS_CHK  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    // physical slot of logical position k in the circular active list
    function automatic logic [REG_BITS-1:0] slot_addr(input logic [REG_BITS-1:0] h,
                                                      input logic [CNT_BITS-1:0] k);
        logic [CNT_BITS:0] s;
        s = (CNT_BITS+1)'(h) + (CNT_BITS+1)'(k);
        if (s >= (CNT_BITS+1)'(MAX_REGS))
        begin
            s = s - (CNT_BITS+1)'(MAX_REGS);
        end
        return s[REG_BITS-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [REG_BITS-1:0] head_reg, head_next;
    logic [CNT_BITS-1:0] act_cnt_reg, act_cnt_next;
    logic [CNT_BITS-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_BITS-1:0] k_reg, k_next;

    // current item
    logic [ORD_BITS-1:0] def_reg, def_next;
    logic [ORD_BITS-1:0] end_reg, end_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                arg_ok_reg, arg_ok_next;
    logic [REG_BITS-1:0] arg_idx_reg, arg_idx_next;
    logic [REG_BITS-1:0] res_reg, res_next;
    logic                reused_reg, reused_next;
    logic                spill_reg, spill_next;
    logic [TAG_BITS-1:0] spill_tag_reg, spill_tag_next;
    logic                err_reg, err_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_REG_W-1:0] o_reg_reg, o_reg_next;
    logic                 o_reused_reg, o_reused_next;
    logic                 o_spill_reg, o_spill_next;
    logic [TAG_BITS-1:0]  o_tag_reg, o_tag_next;
    logic                 o_err_reg, o_err_next;

    // memory ports
    am_ctl_t             am_ctl;
    logic [REG_BITS-1:0] am_raddr, am_waddr, am_wreg;
    logic [ORD_BITS-1:0] am_wend, am_rend;
    logic [TAG_BITS-1:0] am_wtag, am_rtag;
    logic [REG_BITS-1:0] am_rreg;
    fl_ctl_t             fl_ctl;
    logic [REG_BITS-1:0] fl_raddr, fl_waddr, fl_wdata, fl_rdata;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    // allocation sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        act_cnt_next   = act_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        k_next         = k_reg;
        def_next       = def_reg;
        end_next       = end_reg;
        tag_next       = tag_reg;
        arg_ok_next    = arg_ok_reg;
        arg_idx_next   = arg_idx_reg;
        res_next       = res_reg;
        reused_next    = reused_reg;
        spill_next     = spill_reg;
        spill_tag_next = spill_tag_reg;
        err_next       = err_reg;

        out_valid_next = out_valid_reg && !out_ready;
        o_reg_next     = o_reg_reg;
        o_reused_next  = o_reused_reg;
        o_spill_next   = o_spill_reg;
        o_tag_next     = o_tag_reg;
        o_err_next     = o_err_reg;

        am_ctl   = '0;
        am_raddr = '0;
        am_waddr = '0;
        am_wend  = am_rend;
        am_wtag  = am_rtag;
        am_wreg  = am_rreg;
        fl_ctl   = '0;
        fl_raddr = '0;
        fl_waddr = '0;
        fl_wdata = am_rreg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    act_cnt_next = '0;
                    fl_ctl.clear = 1'b1;
                    if (int'(active_registers) > MAX_REGS)
                    begin
                        free_cnt_next = CNT_BITS'(MAX_REGS);
                    end
                    else
                    begin
                        free_cnt_next = CNT_BITS'(active_registers);
                    end
                end
                else if (in_valid)
                begin
                    def_next       = def_ordinal;
                    end_next       = end_ordinal;
                    tag_next       = value_tag;
                    arg_ok_next    = arg_reg_valid && (int'(arg_reg) < MAX_REGS);
                    arg_idx_next   = REG_BITS'(arg_reg);
                    res_next       = '0;
                    reused_next    = 1'b0;
                    spill_next     = 1'b0;
                    spill_tag_next = '0;
                    err_next       = 1'b0;
                    state_next     = S_EXP_RD;
                end
            end
            // expiry: pop intervals ending before the definition
            S_EXP_RD:
            begin
                k_next = '0;
                if (act_cnt_reg == '0)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    am_ctl.rd_en = 1'b1;
                    am_raddr     = head_reg;
                    state_next   = S_EXP_CHK;
                end
            end
            S_EXP_CHK:
            begin
                if (am_rend < def_reg)
                begin
                    if (free_cnt_reg < CNT_BITS'(MAX_REGS))
                    begin
                        fl_ctl.wr_en  = 1'b1;
                        fl_waddr      = free_cnt_reg[REG_BITS-1:0];
                        free_cnt_next = free_cnt_reg + CNT_BITS'(1);
                    end
                    head_next    = slot_addr(head_reg, CNT_BITS'(1));
                    act_cnt_next = act_cnt_reg - CNT_BITS'(1);
                    state_next   = S_EXP_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            // search the intervals ending at the definition for the argument
            S_SCAN_RD:
            begin
                if (!arg_ok_reg || (k_reg >= act_cnt_reg))
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    am_ctl.rd_en = 1'b1;
                    am_raddr     = slot_addr(head_reg, k_reg);
                    state_next   = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                priority if (am_rend != def_reg)
                begin
                    state_next = S_ALLOC;
                end
                else if (am_rreg == arg_idx_reg)
                begin
                    res_next    = arg_idx_reg;
                    reused_next = 1'b1;
                    state_next  = S_MV_RD;
                end
                else
                begin
                    k_next     = k_reg + CNT_BITS'(1);
                    state_next = S_SCAN_RD;
                end
            end
            // close the reused slot by moving earlier ties up one place
            S_MV_RD:
            begin
                if (k_reg == '0)
                begin
                    head_next    = slot_addr(head_reg, CNT_BITS'(1));
                    act_cnt_next = act_cnt_reg - CNT_BITS'(1);
                    k_next       = act_cnt_reg - CNT_BITS'(1);
                    state_next   = S_INS_RD;
                end
                else
                begin
                    am_ctl.rd_en = 1'b1;
                    am_raddr     = slot_addr(head_reg, k_reg - CNT_BITS'(1));
                    state_next   = S_MV_WR;
                end
            end
            S_MV_WR:
            begin
                am_ctl.wr_en = 1'b1;
                am_waddr     = slot_addr(head_reg, k_reg);
                k_next       = k_reg - CNT_BITS'(1);
                state_next   = S_MV_RD;
            end
            // fresh register, spill the furthest interval, or flag an error if none is left
            S_ALLOC:
            begin
                priority if (free_cnt_reg != '0)
                begin
                    fl_ctl.rd_en = 1'b1;
                    fl_raddr     = '0;
                    state_next   = S_FL_HEAD;
                end
                else if (act_cnt_reg != '0)
                begin
                    am_ctl.rd_en = 1'b1;
                    am_raddr     = slot_addr(head_reg, act_cnt_reg - CNT_BITS'(1));
                    state_next   = S_SPILL;
                end
                else
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SPILL:
            begin
                spill_next     = 1'b1;
                spill_tag_next = am_rtag;
                res_next       = am_rreg;
                act_cnt_next   = act_cnt_reg - CNT_BITS'(1);
                k_next         = act_cnt_reg - CNT_BITS'(1);
                state_next     = S_INS_RD;
            end
            S_FL_HEAD:
            begin
                res_next      = fl_rdata;
                free_cnt_next = free_cnt_reg - CNT_BITS'(1);
                k_next        = act_cnt_reg;
                if (free_cnt_reg == CNT_BITS'(1))
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    fl_ctl.rd_en = 1'b1;
                    fl_raddr     = free_cnt_next[REG_BITS-1:0];
                    state_next   = S_FL_MOVE;
                end
            end
            S_FL_MOVE:
            begin
                fl_ctl.wr_en = 1'b1;
                fl_waddr     = '0;
                fl_wdata     = fl_rdata;
                state_next   = S_INS_RD;
            end
            // sorted insertion from the tail
            S_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    am_ctl.wr_en = 1'b1;
                    am_waddr     = head_reg;
                    am_wend      = end_reg;
                    am_wtag      = tag_reg;
                    am_wreg      = res_reg;
                    act_cnt_next = act_cnt_reg + CNT_BITS'(1);
                    state_next   = S_DONE;
                end
                else
                begin
                    am_ctl.rd_en = 1'b1;
                    am_raddr     = slot_addr(head_reg, k_reg - CNT_BITS'(1));
                    state_next   = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                am_ctl.wr_en = 1'b1;
                am_waddr     = slot_addr(head_reg, k_reg);
                if (am_rend > end_reg)
                begin
                    k_next     = k_reg - CNT_BITS'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    am_wend      = end_reg;
                    am_wtag      = tag_reg;
                    am_wreg      = res_reg;
                    act_cnt_next = act_cnt_reg + CNT_BITS'(1);
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_reg_next     = err_reg ? REG_NONE : OUT_REG_W'(res_reg);
                    o_reused_next  = reused_reg;
                    o_spill_next   = spill_reg;
                    o_tag_next     = spill_tag_reg;
                    o_err_next     = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            act_cnt_reg   <= '0;
            free_cnt_reg  <= CNT_BITS'(INIT_REGS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            act_cnt_reg   <= act_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        def_reg       <= def_next;
        end_reg       <= end_next;
        tag_reg       <= tag_next;
        arg_ok_reg    <= arg_ok_next;
        arg_idx_reg   <= arg_idx_next;
        res_reg       <= res_next;
        reused_reg    <= reused_next;
        spill_reg     <= spill_next;
        spill_tag_reg <= spill_tag_next;
        err_reg       <= err_next;
        o_reg_reg     <= o_reg_next;
        o_reused_reg  <= o_reused_next;
        o_spill_reg   <= o_spill_next;
        o_tag_reg     <= o_tag_next;
        o_err_reg     <= o_err_next;
    end

    lsra_active_mem #(
        .MAX_REGS (MAX_REGS),
        .ORD_BITS (ORD_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_active_mem (
        .clk     (clk),
        .ctl     (am_ctl),
        .rd_addr (am_raddr),
        .wr_addr (am_waddr),
        .wr_end  (am_wend),
        .wr_tag  (am_wtag),
        .wr_reg  (am_wreg),
        .rd_end  (am_rend),
        .rd_tag  (am_rtag),
        .rd_reg  (am_rreg)
    );

    lsra_free_list #(
        .MAX_REGS (MAX_REGS)
    ) u_free_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fl_ctl),
        .rd_addr (fl_raddr),
        .wr_addr (fl_waddr),
        .wr_data (fl_wdata),
        .rd_data (fl_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign assigned_reg = o_reg_reg;
    assign reused_arg   = o_reused_reg;
    assign spill_valid  = o_spill_reg;
    assign spilled_tag  = o_tag_reg;
    assign alloc_error  = o_err_reg;

    // active plus free registers never exceed MAX_REGS
    `LSRA_ASSERT_IMP(a_reg_conserve, clk, rst_n, 1'b1,
        (int'(act_cnt_reg) + int'(free_cnt_reg) <= MAX_REGS),
        "active plus free registers exceed MAX_REGS")
    // an accepted transaction starts the sequencer
    `LSRA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready,
        state_reg == S_EXP_RD, "accepted transaction did not start expiry")
    // a failed allocation reports nothing else
    `LSRA_ASSERT_IMP(a_err_clean, clk, rst_n, out_valid_reg && o_err_reg,
        (o_reg_reg == REG_NONE) && !o_reused_reg && !o_spill_reg,
        "allocation error with other result fields set")
    // reuse of the argument register never spills
    `LSRA_ASSERT_IMP(a_reuse_no_spill, clk, rst_n, out_valid_reg && o_reused_reg,
        !o_spill_reg && !o_err_reg, "reused argument together with spill or error")

endmodule

FILE: verif/linear_scan_register_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// Linear scan register allocator unit testbench
// Drives live intervals through the allocator and compares every assignment
// with a behavioral allocator kept in step with each accepted transaction.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsra_pkg::*;

    localparam int NREGS = 32;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [4:0]  reg_idx;
        logic        reused;
        logic        spilled;
        logic [15:0] spill_tag;
        logic        err;
    } assign_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  active_registers;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] def_ordinal;
    logic [15:0] end_ordinal;
    logic [15:0] value_tag;
    logic        arg_reg_valid;
    logic [4:0]  arg_reg;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  assigned_reg;
    logic        reused_arg;
    logic        spill_valid;
    logic [15:0] spilled_tag;
    logic        alloc_error;

    // allocator model state
    logic [15:0] act_end [NREGS];
    logic [15:0] act_tag [NREGS];
    logic [4:0]  act_reg [NREGS];
    int          act_cnt;
    logic [4:0]  free_regs [NREGS];
    int          free_cnt;

    assign_t     expected_q[$];
    int          error_count;
    int          idle_cycles;
    bit          drive_idle;
    int          burst_left;
    logic [15:0] prog_ord;

    linear_scan_register_allocator_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .active_registers(active_registers),
        .in_valid(in_valid), .in_ready(in_ready),
        .def_ordinal(def_ordinal), .end_ordinal(end_ordinal),
        .value_tag(value_tag), .arg_reg_valid(arg_reg_valid), .arg_reg(arg_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .assigned_reg(assigned_reg), .reused_arg(reused_arg),
        .spill_valid(spill_valid), .spilled_tag(spilled_tag),
        .alloc_error(alloc_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // clear active list and refill free list
    function automatic void alloc_init(int count);
        act_cnt = 0;
        free_cnt = count;
        for (int i = 0; i < NREGS; i++)
            free_regs[i] = 5'(i);
    endfunction

    function automatic void active_remove(int pos);
        for (int i = pos; i + 1 < act_cnt; i++)
        begin
            act_end[i] = act_end[i + 1];
            act_tag[i] = act_tag[i + 1];
            act_reg[i] = act_reg[i + 1];
        end
        act_cnt--;
    endfunction

    // sorted insert, ties after existing entries
    function automatic void active_insert(logic [15:0] e, logic [15:0] t, logic [4:0] r);
        int pos;
        pos = act_cnt;
        while (pos > 0 && act_end[pos - 1] > e)
        begin
            act_end[pos] = act_end[pos - 1];
            act_tag[pos] = act_tag[pos - 1];
            act_reg[pos] = act_reg[pos - 1];
            pos--;
        end
        act_end[pos] = e;
        act_tag[pos] = t;
        act_reg[pos] = r;
        act_cnt++;
    endfunction

    function automatic assign_t allocate(logic [15:0] d, logic [15:0] e, logic [15:0] t,
                                         logic av, logic [4:0] ar);
        assign_t res;
        int      slot;
        res = '0;
        res.reg_idx = REG_NONE;
        while (act_cnt > 0 && act_end[0] < d)
        begin
            free_regs[free_cnt] = act_reg[0];
            free_cnt++;
            active_remove(0);
        end
        slot = -1;
        if (av)
            for (int i = 0; i < act_cnt; i++)
                if (act_reg[i] == ar)
                    slot = i;
        if (slot >= 0 && act_end[slot] <= d)
        begin
            active_remove(slot);
            active_insert(e, t, ar);
            res.reg_idx = ar;
            res.reused = 1'b1;
        end
        else
        begin
            if (free_cnt == 0 && act_cnt > 0)
            begin
                res.spilled = 1'b1;
                res.spill_tag = act_tag[act_cnt - 1];
                free_regs[free_cnt] = act_reg[act_cnt - 1];
                free_cnt++;
                active_remove(act_cnt - 1);
            end
            if (free_cnt > 0)
            begin
                res.reg_idx = free_regs[0];
                free_cnt--;
                free_regs[0] = free_regs[free_cnt];
                active_insert(e, t, res.reg_idx);
            end
            else
                res.err = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // output checker and receiver stall pattern
    always @(posedge clk)
    begin
        assign_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (assigned_reg !== want.reg_idx)
                    report_mismatch("assigned_reg", int'(assigned_reg), int'(want.reg_idx));
                if (reused_arg !== want.reused)
                    report_mismatch("reused_arg", int'(reused_arg), int'(want.reused));
                if (spill_valid !== want.spilled)
                    report_mismatch("spill_valid", int'(spill_valid), int'(want.spilled));
                if (spilled_tag !== want.spill_tag)
                    report_mismatch("spilled_tag", int'(spilled_tag), int'(want.spill_tag));
                if (alloc_error !== want.err)
                    report_mismatch("alloc_error", int'(alloc_error), int'(want.err));
            end
        end
    end

    always @(negedge clk)
        out_ready <= drive_idle ? 1'b1 : ($urandom_range(0, 9) < 7);

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one interval transaction, with burst gaps
    task automatic send_interval(logic [15:0] d, logic [15:0] e, logic [15:0] t,
                                 logic av, logic [4:0] ar);
        int gap;
        gap = 0;
        if (!drive_idle)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 12);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        // valid drops only across a real gap
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        def_ordinal <= d;
        end_ordinal <= e;
        value_tag <= t;
        arg_reg_valid <= av;
        arg_reg <= ar;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(allocate(d, e, t, av, ar));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg_count(logic [5:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        active_registers <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        alloc_init(v > NREGS ? NREGS : int'(v));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random well-formed program chunk
    task automatic send_program(int n, int span);
        logic [15:0] e;
        logic [4:0]  ar;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                prog_ord = 16'($urandom);
            else
                prog_ord = prog_ord + 16'($urandom_range(0, 2));
            e = prog_ord + 16'($urandom_range(0, span));
            if ($urandom_range(0, 9) == 0)
                e = 16'($urandom);
            ar = (act_cnt > 0 && $urandom_range(0, 3) != 0)
                 ? act_reg[$urandom_range(0, act_cnt - 1)] : 5'($urandom);
            send_interval(prog_ord, e, 16'($urandom), $urandom_range(0, 3) != 0, ar);
        end
    endtask

    task automatic test_directed();
        send_interval(16'h0000, 16'h0000, 16'h0000, 1'b0, 5'd0);
        send_interval(16'h0000, 16'h0005, 16'hFFFF, 1'b1, 5'd0);
        send_interval(16'h0005, 16'h0009, 16'h1234, 1'b1, 5'd1);
        send_interval(16'h0005, 16'h0006, 16'h0042, 1'b1, 5'd31);
        send_interval(16'h0006, 16'hFFFF, 16'hAAAA, 1'b1, 5'd1);
        send_interval(16'hFFFF, 16'hFFFF, 16'h5555, 1'b1, 5'd0);
        send_interval(16'hFFFF, 16'h0000, 16'h7777, 1'b1, 5'd31);
    endtask

    task automatic test_spill();
        write_reg_count(6'd1);
        send_interval(16'd10, 16'd100, 16'hBEEF, 1'b0, 5'd0);
        send_interval(16'd11, 16'd50, 16'hCAFE, 1'b1, 5'd0);
        send_interval(16'd12, 16'd60, 16'hF00D, 1'b0, 5'd0);
        send_interval(16'd60, 16'd61, 16'h0001, 1'b1, 5'd0);
        write_reg_count(6'd2);
        send_program(20, 8);
    endtask

    task automatic test_zero_regs();
        write_reg_count(6'd0);
        send_interval(16'd1, 16'd2, 16'h0101, 1'b1, 5'd0);
        send_interval(16'd3, 16'd4, 16'h0202, 1'b0, 5'd7);
        write_reg_count(6'd63);
        send_program(30, 20);
    endtask

    task automatic test_random();
        logic [5:0] sizes[6] = '{6'd32, 6'd4, 6'd16, 6'd40, 6'd1, 6'd7};
        foreach (sizes[k])
        begin
            write_reg_count(k == 5 ? 6'($urandom_range(0, 63)) : sizes[k]);
            drive_idle = (k == 2);
            send_program(280, $urandom_range(1, 3) * 12);
            for (int j = 0; j < 20; j++)
                send_interval(16'($urandom), 16'($urandom), 16'($urandom),
                              1'($urandom), 5'($urandom));
        end
        drive_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        active_registers = '0;
        in_valid = 1'b0;
        def_ordinal = '0;
        end_ordinal = '0;
        value_tag = '0;
        arg_reg_valid = 1'b0;
        arg_reg = '0;
        out_ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        drive_idle = 1'b0;
        burst_left = 0;
        prog_ord = '0;
        alloc_init(RESET_REGS);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_spill();
        test_zero_regs();
        test_random();
        wait_drained();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
